// ----- hdl/asm_pkg.sv -----
// ---------------------------------------------------------------------------
// asm_pkg: shared types and constants for the anchored substring matcher
// Holds register indexes, field widths and the configuration bundle that
// the register bank hands to the cells and the control logic.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package asm_pkg;

  // pattern register geometry
  localparam int PAT_REG_BYTES = 16;
  localparam int PAT_W         = 8 * PAT_REG_BYTES;
  localparam int PAT_IDX_W     = 4;
  localparam int LEN_W         = 5;
  localparam int BYTE_W        = 8;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;

  // default window depth
  localparam int PATTERN_MAX_DEF = 16;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW  = 3'd0,
    REG_PAT_HIGH = 3'd1,
    REG_PAT_LEN  = 3'd2,
    REG_ANC_STA  = 3'd3,
    REG_ANC_END  = 3'd4
  } reg_idx_t;

  // configuration seen by the datapath
  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] len_eff;
    logic             anchor_start;
    logic             anchor_end;
  } cfg_t;

endpackage

// ----- hdl/asm_cfg.sv -----
// ---------------------------------------------------------------------------
// asm_cfg: configuration register bank
// Takes register writes and presents the pattern, the clamped pattern
// length and the anchor flags.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module asm_cfg import asm_pkg::*; #(
  parameter int CELLS = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [CFG_DATA_W-1:0] pat_lo_r;
  logic [CFG_DATA_W-1:0] pat_hi_r;
  logic [LEN_W-1:0]      len_r;
  logic                  anc_sta_r;
  logic                  anc_end_r;
  logic [LEN_W-1:0]      len_eff;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r  <= '0;
      pat_hi_r  <= '0;
      len_r     <= LEN_W'(1);
      anc_sta_r <= 1'b0;
      anc_end_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PAT_LOW:  pat_lo_r  <= cfg_data;
        REG_PAT_HIGH: pat_hi_r  <= cfg_data;
        REG_PAT_LEN:  len_r     <= cfg_data[LEN_W-1:0];
        REG_ANC_STA:  anc_sta_r <= cfg_data[0];
        REG_ANC_END:  anc_end_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero length counts as one, long patterns clamp to the window depth
  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(CELLS)) begin
      len_eff = LEN_W'(CELLS);
    end else begin
      len_eff = len_r;
    end
  end

  assign cfg.pattern      = {pat_hi_r, pat_lo_r};
  assign cfg.len_eff      = len_eff;
  assign cfg.anchor_start = anc_sta_r;
  assign cfg.anchor_end   = anc_end_r;

endmodule

// ----- hdl/asm_cell.sv -----
// ---------------------------------------------------------------------------
// asm_cell: one window position
// Holds one data byte, passes it to the next cell on every beat and checks
// the byte it takes in against the pattern byte that lines up with it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module asm_cell import asm_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              shift,
  input  logic [BYTE_W-1:0] byte_in,
  output logic [BYTE_W-1:0] byte_out,
  input  cfg_t              cfg,
  output logic              ok
);

  logic [BYTE_W-1:0]    byte_r;
  logic [BYTE_W-1:0]    byte_nxt;
  logic [LEN_W-1:0]     pos_full;
  logic [PAT_IDX_W-1:0] pat_idx;
  logic                 active;

  assign byte_nxt = shift ? byte_in : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_out = byte_r;

  // this cell sits at pattern index len-1-IDX once the new byte is in
  assign active   = LEN_W'(IDX) < cfg.len_eff;
  assign pos_full = cfg.len_eff - LEN_W'(1) - LEN_W'(IDX);
  assign pat_idx  = pos_full[PAT_IDX_W-1:0];

  // compare the byte arriving on this beat
  assign ok = !active || (byte_in == cfg.pattern[pat_idx*BYTE_W +: BYTE_W]);

endmodule

// ----- hdl/asm_ctrl.sv -----
// ---------------------------------------------------------------------------
// asm_ctrl: string tracking and result register
// Counts the bytes of the current string, keeps the found flag, applies
// the anchor rules on the last byte and holds the result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module asm_ctrl import asm_pkg::*; #(
  parameter int CELLS = PATTERN_MAX_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_last_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic out_matched,
  input  cfg_t cfg,
  input  logic window_ok,
  output logic shift
);

  localparam int SEEN_W = $clog2(CELLS + 2);

  logic [SEEN_W-1:0] seen_r;
  logic [SEEN_W-1:0] seen_nxt;
  logic              found_r;
  logic              found_nxt;
  logic              out_valid_r;
  logic              out_matched_r;
  logic [LEN_W-1:0]  seen_ext;
  logic              hit;
  logic              exact;
  logic              result;

  // take a byte unless a result waits and is held
  assign in_stall = out_valid_r && out_stall;
  assign shift    = in_valid && !in_stall;

  // byte count saturates one past the window depth
  assign seen_nxt = (seen_r < SEEN_W'(CELLS + 1)) ? seen_r + SEEN_W'(1) : seen_r;
  assign seen_ext = LEN_W'(seen_nxt);

  assign hit   = window_ok && (seen_ext >= cfg.len_eff);
  assign exact = (seen_ext == cfg.len_eff);

  // start anchor only counts the occurrence at the head of the string
  assign found_nxt = found_r || (cfg.anchor_start ? (hit && exact) : hit);

  always_comb begin
    priority if (cfg.anchor_start && cfg.anchor_end) begin
      result = hit && exact;
    end else if (cfg.anchor_end) begin
      result = hit;
    end else begin
      result = found_nxt;
    end
  end

  // string state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      found_r <= 1'b0;
    end else if (shift) begin
      if (in_last_byte) begin
        seen_r  <= '0;
        found_r <= 1'b0;
      end else begin
        seen_r  <= seen_nxt;
        found_r <= found_nxt;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (shift && in_last_byte) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift && in_last_byte) begin
      out_matched_r <= result;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

endmodule

// ----- hdl/anchored_substring_match_top.sv -----
// ---------------------------------------------------------------------------
// anchored_substring_match_top: literal pattern match over a byte stream
// A row of byte cells forms a sliding window that is compared against the
// configured pattern on every byte; one result beat per string.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_data_byte, in_last_byte
//   out_     output     out_valid/out_stall  out_matched
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle while in_stall is low; the window compare across the
// cells is combinational, and the result beat is registered and appears in
// the cycle after the last byte is taken.
// Synchronous active-low reset clears the config registers, string state and out_valid.
// in_stall rises only while a result beat is held by out_stall.
// cfg_ready is always high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module anchored_substring_match_top import asm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_matched,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // only positions up to the pattern register size can ever be compared
  localparam int CELLS = (PATTERN_MAX < PAT_REG_BYTES) ? PATTERN_MAX : PAT_REG_BYTES;

  cfg_t              cfg;
  logic              shift;
  logic [CELLS-1:0]  ok_vec;
  logic [BYTE_W-1:0] chain [CELLS+1];

  asm_cfg #(.CELLS(CELLS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // window cells, newest byte enters cell zero
  assign chain[0] = in_data_byte;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    asm_cell #(.IDX(k)) u_cell (
      .clk      (clk),
      .shift    (shift),
      .byte_in  (chain[k]),
      .byte_out (chain[k+1]),
      .cfg      (cfg),
      .ok       (ok_vec[k])
    );
  end

  asm_ctrl #(.CELLS(CELLS)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_matched  (out_matched),
    .cfg          (cfg),
    .window_ok    (&ok_vec),
    .shift        (shift)
  );

endmodule
